[sv/tiff_strip_pixel_unpacker_assert.svh]
// assertion macros for the tiff strip pixel unpacker
// no dependencies; included by the rtl files that carry assertions
`ifndef TIFF_STRIP_PIXEL_UNPACKER_ASSERT_SVH
`define TIFF_STRIP_PIXEL_UNPACKER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TSPU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define TSPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TSPU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define TSPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/tspu_pkg.sv]
// shared types, codes and constants of the tiff strip pixel unpacker
// no dependencies
`default_nettype none

package tspu_pkg;

	// sizes
	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int PAL_W               = 24;
	localparam int PADDR_W             = 4;
	localparam int PDATA_W             = 32;

	// supported sample depths
	localparam logic [4:0] BPP_RGB     = 5'd24;
	localparam logic [4:0] BPP_GRAY    = 5'd8;
	localparam logic [4:0] BPP_BILEVEL = 5'd1;

	// photometric interpretations
	localparam logic [1:0] PHOTO_WHITE_ZERO = 2'd0;
	localparam logic [1:0] PHOTO_BLACK_ZERO = 2'd1;
	localparam logic [1:0] PHOTO_RGB        = 2'd2;
	localparam logic [1:0] PHOTO_PALETTE    = 2'd3;

	// request commands
	localparam logic CMD_DATA    = 1'b0;
	localparam logic CMD_PALETTE = 1'b1;

	// palette channels
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// result status
	localparam logic STATUS_OK          = 1'b0;
	localparam logic STATUS_UNSUPPORTED = 1'b1;

	// bilevel levels
	localparam logic [7:0] LEVEL_WHITE = 8'hFF;
	localparam logic [7:0] LEVEL_BLACK = 8'h00;

	// reset values of the registers
	localparam logic [4:0]  BPP_RESET   = 5'd8;
	localparam logic [1:0]  PHOTO_RESET = 2'd1;
	localparam logic [15:0] WIDTH_RESET = 16'd1;

	// register indexes
	typedef enum logic [1:0] {
		REG_BITS_PER_PIXEL = 2'd0,
		REG_PHOTOMETRIC    = 2'd1,
		REG_IMAGE_WIDTH    = 2'd2
	} reg_idx_t;

	// decoded pixel mode
	typedef enum logic [2:0] {
		MODE_RGB     = 3'd0,
		MODE_GRAY    = 3'd1,
		MODE_PALETTE = 3'd2,
		MODE_BILEVEL = 3'd3,
		MODE_ERROR   = 3'd4
	} mode_t;

	// rgb byte gathering phase
	typedef enum logic [2:0] {
		PH_RED   = 3'b001,
		PH_GREEN = 3'b010,
		PH_BLUE  = 3'b100
	} phase_t;

	// configuration seen by the datapath
	typedef struct packed {
		logic [4:0]  bits_per_pixel;
		logic [1:0]  photometric;
		logic [15:0] image_width;
	} cfg_t;

	// input request
	typedef struct packed {
		logic        command;
		logic [7:0]  data_byte;
		logic [7:0]  palette_index;
		logic [1:0]  palette_channel;
		logic [15:0] palette_word;
	} src_item_t;

	// output pixel
	typedef struct packed {
		logic       status;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
		logic       last;
	} pix_item_t;

endpackage

`default_nettype wire

[sv/tiff_strip_pixel_unpacker.sv]
// top level of the tiff strip pixel unpacker: apb registers, palette ram, core
// depends on tspu_pkg, tspu_cfg_regs, tspu_ram, tspu_core
//
//   channel   signals                        direction   moves
//   src       src_valid/src_stall/src_item   in          strip byte or palette word request
//   pix       pix_valid/pix_stall/pix_item   out         rgb24 pixel or error result
//   apb       psel/penable/pwrite/paddr/...  in          register write and read
//
// one request per cycle for data and palette bytes unless the stage is held;
// rgb takes three bytes per pixel; a bilevel byte holds the stage until it has given
// min(8, pixels left in row) pixels, one per cycle via the output register while not stalled
// palette read at accept, merged and written back in the cycle after, with forwarding
// reset clears control state only; palette content is undefined until written
// a stalled output blocks the stage once the output register is full
`default_nettype none

module tiff_strip_pixel_unpacker #(
	parameter int PALETTE_ENTRIES = tspu_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         src_valid,
	output      logic                         src_stall,
	input  wire tspu_pkg::src_item_t          src_item,
	output      logic                         pix_valid,
	input  wire logic                         pix_stall,
	output      tspu_pkg::pix_item_t          pix_item,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tspu_pkg::PADDR_W-1:0] paddr,
	input  wire logic [tspu_pkg::PDATA_W-1:0] pwdata,
	output      logic [tspu_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready
);
	import tspu_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	cfg_t             cfg;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [PAL_W-1:0] ram_rdata;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [PAL_W-1:0] ram_wdata;

	// configuration registers
	tspu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// palette store
	tspu_ram #(
		.WIDTH (PAL_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// unpacking datapath
	tspu_core #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_item  (pix_item),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

endmodule

`default_nettype wire

[sv/tspu_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module tspu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/tspu_cfg_regs.sv]
// apb configuration registers: bits_per_pixel, photometric, image_width
// depends on tspu_pkg
`default_nettype none

module tspu_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tspu_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [tspu_pkg::PDATA_W-1:0]   pwdata,
	output      logic [tspu_pkg::PDATA_W-1:0]   prdata,
	output      logic                           pready,
	output      tspu_pkg::cfg_t                 cfg
);
	import tspu_pkg::*;

	logic     wr_en;
	reg_idx_t reg_sel;
	cfg_t     cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_per_pixel <= BPP_RESET;
			cfg_q.photometric    <= PHOTO_RESET;
			cfg_q.image_width    <= WIDTH_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_BITS_PER_PIXEL: cfg_q.bits_per_pixel <= pwdata[4:0];
				REG_PHOTOMETRIC:    cfg_q.photometric    <= pwdata[1:0];
				REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_BITS_PER_PIXEL: prdata = PDATA_W'(cfg_q.bits_per_pixel);
			REG_PHOTOMETRIC:    prdata = PDATA_W'(cfg_q.photometric);
			REG_IMAGE_WIDTH:    prdata = PDATA_W'(cfg_q.image_width);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[sv/tspu_core.sv]
// unpacking stage: palette read-modify-write, rgb gathering, bilevel expansion,
// column tracking and output register; depends on tspu_pkg and the assert header
`default_nettype none
`include "tiff_strip_pixel_unpacker_assert.svh"

module tspu_core #(
	parameter int PALETTE_ENTRIES = tspu_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tspu_pkg::cfg_t                     cfg,
	input  wire logic                               src_valid,
	output      logic                               src_stall,
	input  wire tspu_pkg::src_item_t                src_item,
	output      logic                               pix_valid,
	input  wire logic                               pix_stall,
	output      tspu_pkg::pix_item_t                pix_item,
	output      logic                               ram_re,
	output      logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr,
	input  wire logic [tspu_pkg::PAL_W-1:0]         ram_rdata,
	output      logic                               ram_we,
	output      logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr,
	output      logic [tspu_pkg::PAL_W-1:0]         ram_wdata
);
	import tspu_pkg::*;

	localparam int         AW          = $clog2(PALETTE_ENTRIES);
	localparam logic [8:0] ENTRIES_LIM = 9'(PALETTE_ENTRIES);

	// stage 1 request and its palette data
	logic             s1_valid_q;
	src_item_t        item_s1;
	logic             fwd_hit_q;
	logic [PAL_W-1:0] fwd_data_q;
	logic [2:0]       bit_idx_q;

	// architectural state
	phase_t      phase_q;
	logic [7:0]  red_hold_q;
	logic [7:0]  green_hold_q;
	logic [15:0] column_q;

	// output register
	logic      out_valid_q;
	pix_item_t out_q;

	logic             src_accept;
	logic             slot_free;
	logic             need_result;
	logic             emit;
	logic             s1_done;
	mode_t            mode;
	pix_item_t        res;
	logic [PAL_W-1:0] entry_s1;
	logic [PAL_W-1:0] wr_entry;
	logic             rd_in_range;
	logic             idx_in_range;
	logic [15:0]      width_m1;
	logic             row_end;
	logic [15:0]      column_next;
	logic [7:0]       gray_level;
	logic [7:0]       bw_level;

	// mode decode from the configuration
	always_comb begin
		mode = MODE_ERROR;
		if (cfg.bits_per_pixel == BPP_RGB && cfg.photometric == PHOTO_RGB) begin
			mode = MODE_RGB;
		end else if (cfg.bits_per_pixel == BPP_GRAY && cfg.photometric == PHOTO_PALETTE) begin
			mode = MODE_PALETTE;
		end else if (cfg.bits_per_pixel == BPP_GRAY &&
		             cfg.photometric inside {PHOTO_WHITE_ZERO, PHOTO_BLACK_ZERO}) begin
			mode = MODE_GRAY;
		end else if (cfg.bits_per_pixel == BPP_BILEVEL &&
		             cfg.photometric inside {PHOTO_WHITE_ZERO, PHOTO_BLACK_ZERO}) begin
			mode = MODE_BILEVEL;
		end
	end

	// input handshake and palette read at accept
	assign src_stall  = s1_valid_q && !s1_done;
	assign src_accept = src_valid && !src_stall;
	assign ram_re     = src_accept;
	assign ram_raddr  = (src_item.command == CMD_PALETTE) ? src_item.palette_index[AW-1:0]
	                                                      : src_item.data_byte[AW-1:0];

	// palette entry with forwarding of the write retiring at the read edge
	assign entry_s1     = fwd_hit_q ? fwd_data_q : ram_rdata;
	assign rd_in_range  = {1'b0, item_s1.data_byte} < ENTRIES_LIM;
	assign idx_in_range = {1'b0, item_s1.palette_index} < ENTRIES_LIM;

	// palette byte merge
	always_comb begin
		wr_entry = entry_s1;
		case (item_s1.palette_channel)
			CH_RED:   wr_entry[23:16] = item_s1.palette_word[15:8];
			CH_GREEN: wr_entry[15:8]  = item_s1.palette_word[15:8];
			CH_BLUE:  wr_entry[7:0]   = item_s1.palette_word[15:8];
			default: ;
		endcase
	end

	assign ram_we    = s1_valid_q && item_s1.command == CMD_PALETTE && idx_in_range &&
	                   item_s1.palette_channel inside {CH_RED, CH_GREEN, CH_BLUE};
	assign ram_waddr = item_s1.palette_index[AW-1:0];
	assign ram_wdata = wr_entry;

	// column advance, zero width counts as one
	assign width_m1    = (cfg.image_width == 16'd0) ? 16'd0 : cfg.image_width - 16'd1;
	assign row_end     = column_q >= width_m1;
	assign column_next = row_end ? 16'd0 : column_q + 16'd1;

	// levels for gray and bilevel
	assign gray_level = (cfg.photometric == PHOTO_WHITE_ZERO) ? ~item_s1.data_byte
	                                                          : item_s1.data_byte;
	assign bw_level   = (item_s1.data_byte[3'd7 - bit_idx_q] == cfg.photometric[0])
	                    ? LEVEL_WHITE : LEVEL_BLACK;

	// result selection
	always_comb begin
		need_result = 1'b0;
		res.status  = STATUS_OK;
		res.red     = 8'd0;
		res.green   = 8'd0;
		res.blue    = 8'd0;
		res.row_end = row_end;
		res.last    = 1'b1;
		if (item_s1.command == CMD_DATA) begin
			case (mode)
				MODE_RGB: begin
					need_result = (phase_q == PH_BLUE);
					res.red     = red_hold_q;
					res.green   = green_hold_q;
					res.blue    = item_s1.data_byte;
				end
				MODE_GRAY: begin
					need_result = 1'b1;
					res.red     = gray_level;
					res.green   = gray_level;
					res.blue    = gray_level;
				end
				MODE_PALETTE: begin
					need_result = 1'b1;
					if (rd_in_range) begin
						res.red   = entry_s1[23:16];
						res.green = entry_s1[15:8];
						res.blue  = entry_s1[7:0];
					end
				end
				MODE_BILEVEL: begin
					need_result = 1'b1;
					res.red     = bw_level;
					res.green   = bw_level;
					res.blue    = bw_level;
					res.last    = row_end || bit_idx_q == 3'd7;
				end
				default: begin
					need_result = 1'b1;
					res.status  = STATUS_UNSUPPORTED;
					res.row_end = 1'b0;
				end
			endcase
		end
	end

	assign slot_free = !out_valid_q || !pix_stall;
	assign emit      = s1_valid_q && need_result && slot_free;
	assign s1_done   = s1_valid_q && (!need_result || (emit && res.last));

	// stage 1 occupancy and bilevel bit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			bit_idx_q  <= 3'd0;
			fwd_hit_q  <= 1'b0;
		end else begin
			if (src_accept) begin
				s1_valid_q <= 1'b1;
				fwd_hit_q  <= ram_we && ram_waddr == ram_raddr;
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_done) begin
				bit_idx_q <= 3'd0;
			end else if (emit) begin
				bit_idx_q <= bit_idx_q + 3'd1;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (src_accept) begin
			item_s1    <= src_item;
			fwd_data_q <= ram_wdata;
		end
	end

	// rgb phase, held bytes and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_RED;
			red_hold_q   <= 8'd0;
			green_hold_q <= 8'd0;
			column_q     <= 16'd0;
		end else begin
			if (s1_done && item_s1.command == CMD_DATA) begin
				if (mode == MODE_RGB) begin
					case (phase_q)
						PH_RED: begin
							red_hold_q <= item_s1.data_byte;
							phase_q    <= PH_GREEN;
						end
						PH_GREEN: begin
							green_hold_q <= item_s1.data_byte;
							phase_q      <= PH_BLUE;
						end
						default: phase_q <= PH_RED;
					endcase
				end else begin
					phase_q <= PH_RED;
				end
			end
			if (emit && mode != MODE_ERROR) begin
				column_q <= column_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix_item  = out_q;

	// checks
	`TSPU_ASSERT_IMPLY(a_write_no_emit, clk, arst_n, ram_we, !emit, "palette write with a pixel")
	`TSPU_ASSERT_IMPLY(a_accept_frees, clk, arst_n, src_accept, !s1_valid_q || s1_done, "stage overrun")
	`TSPU_ASSERT_IMPLY(a_bit_idx_busy, clk, arst_n, bit_idx_q != 3'd0, s1_valid_q, "stale bit index")
	`TSPU_ASSERT_NEXT(a_emit_shows, clk, arst_n, emit, pix_valid, "emitted pixel not shown")

endmodule

`default_nettype wire

[tb/tiff_strip_pixel_unpacker_tb.sv]
// self-checking testbench of the tiff strip pixel unpacker: directed and random strip requests
// depends on tspu_pkg and tiff_strip_pixel_unpacker; one predictor tracks config, column and palette
`default_nettype none

module tiff_strip_pixel_unpacker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tspu_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 8;

	// ports
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_stall;
	src_item_t           src_item  = '0;
	logic                pix_valid;
	logic                pix_stall = 1'b0;
	pix_item_t           pix_item;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0]  pwdata    = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// shadow of the registers and the pixel state
	logic [4:0]  cfg_bpp    = BPP_RESET;
	logic [1:0]  cfg_photo  = PHOTO_RESET;
	logic [15:0] cfg_width  = WIDTH_RESET;
	phase_t      rgb_phase  = PH_RED;
	logic [7:0]  red_hold   = '0;
	logic [7:0]  green_hold = '0;
	logic [15:0] column     = '0;
	logic [23:0] palette [PALETTE_ENTRIES_DEF];
	logic [2:0]  pal_set [PALETTE_ENTRIES_DEF];
	logic [7:0]  pal_full_q[$];
	pix_item_t   pixel_q[$];
	pix_item_t   want;

	// run bookkeeping
	int mismatches   = 0;
	int cycles       = 0;
	int pixels_seen  = 0;
	int data_reqs    = 0;
	int pal_reqs     = 0;
	int burst_left   = 0;
	bit src_gaps_on  = 1'b1;
	bit hold_start   = 1'b0;
	int hold_left    = 0;
	int pattern_left = 0;
	int stall_pct    = 0;

	tiff_strip_pixel_unpacker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_item  (pix_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tiff_strip_pixel_unpacker_tb failed");
			$finish;
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_start) begin
			hold_left = HOLD_CYCLES;
			hold_start = 1'b0;
		end
		if (pattern_left == 0) begin
			pattern_left = $urandom_range(8, 64);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		pattern_left--;
		if (hold_left != 0) begin
			pix_stall <= 1'b1;
			hold_left--;
		end else begin
			pix_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	// compare each accepted pixel with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && pix_valid === 1'b1 && pix_stall === 1'b0) begin
			pixels_seen++;
			if (pixel_q.size() == 0) begin
				note_mismatch($sformatf("unexpected pixel st=%0d rgb=%02h%02h%02h re=%0d last=%0d",
					pix_item.status, pix_item.red, pix_item.green, pix_item.blue,
					pix_item.row_end, pix_item.last));
			end else begin
				want = pixel_q.pop_front();
				if (pix_item !== want)
					note_mismatch($sformatf({"expected st=%0d rgb=%02h%02h%02h re=%0d last=%0d",
						" got st=%0d rgb=%02h%02h%02h re=%0d last=%0d"},
						want.status, want.red, want.green, want.blue, want.row_end, want.last,
						pix_item.status, pix_item.red, pix_item.green, pix_item.blue,
						pix_item.row_end, pix_item.last));
			end
		end
	end

	// column counter; returns the row end flag
	function automatic logic next_column();
		logic [15:0] w;
		w = (cfg_width == 16'd0) ? 16'd1 : cfg_width;
		if (column >= w - 16'd1) begin
			column = '0;
			return 1'b1;
		end
		column = column + 16'd1;
		return 1'b0;
	endfunction

	function automatic void push_pixel(input logic st, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic re, input logic lst);
		pix_item_t p;
		p.status  = st;
		p.red     = r;
		p.green   = g;
		p.blue    = b;
		p.row_end = re;
		p.last    = lst;
		pixel_q.push_back(p);
	endfunction

	// expected pixels of one accepted request
	function automatic void predict_pixels(input src_item_t it);
		logic [7:0]  d;
		logic [7:0]  idx;
		logic [7:0]  v;
		logic [23:0] e;
		logic [15:0] w;
		int          cnt;
		d = it.data_byte;
		idx = it.palette_index;
		if (it.command == CMD_PALETTE) begin
			// channel three is ignored
			if (it.palette_channel <= CH_BLUE) begin
				case (it.palette_channel)
					CH_RED:   palette[idx][23:16] = it.palette_word[15:8];
					CH_GREEN: palette[idx][15:8] = it.palette_word[15:8];
					default:  palette[idx][7:0] = it.palette_word[15:8];
				endcase
				if (pal_set[idx] != 3'b111) begin
					pal_set[idx][it.palette_channel] = 1'b1;
					if (pal_set[idx] == 3'b111)
						pal_full_q.push_back(idx);
				end
			end
			return;
		end
		// rgb gathers three bytes
		if (cfg_bpp == BPP_RGB && cfg_photo == PHOTO_RGB) begin
			case (rgb_phase)
				PH_GREEN: begin
					green_hold = d;
					rgb_phase = PH_BLUE;
				end
				PH_BLUE: begin
					push_pixel(STATUS_OK, red_hold, green_hold, d, next_column(), 1'b1);
					rgb_phase = PH_RED;
				end
				default: begin
					red_hold = d;
					rgb_phase = PH_GREEN;
				end
			endcase
			return;
		end
		// any other data byte drops a partial rgb pixel
		rgb_phase = PH_RED;
		if (cfg_bpp == BPP_GRAY && cfg_photo != PHOTO_RGB) begin
			if (cfg_photo == PHOTO_PALETTE)
				e = palette[d];
			else if (cfg_photo == PHOTO_WHITE_ZERO)
				e = {3{8'd255 - d}};
			else
				e = {3{d}};
			push_pixel(STATUS_OK, e[23:16], e[15:8], e[7:0], next_column(), 1'b1);
		end else if (cfg_bpp == BPP_BILEVEL && cfg_photo <= PHOTO_BLACK_ZERO) begin
			// msb first, pad bits after row end dropped
			w = (cfg_width == 16'd0) ? 16'd1 : cfg_width;
			cnt = (column < w) ? int'(w - column) : 1;
			if (cnt > 8)
				cnt = 8;
			for (int i = 0; i < cnt; i++) begin
				v = (d[7-i] == cfg_photo[0]) ? LEVEL_WHITE : LEVEL_BLACK;
				push_pixel(STATUS_OK, v, v, v, next_column(), i == cnt - 1);
			end
		end else begin
			push_pixel(STATUS_UNSUPPORTED, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
		end
	endfunction

	// one request through the source channel, with bursts and gaps
	task automatic send_request(input src_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = src_gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		src_valid <= 1'b1;
		src_item <= it;
		@(posedge clk);
		while (src_stall !== 1'b0) @(posedge clk);
		if (it.command == CMD_PALETTE)
			pal_reqs++;
		else
			data_reqs++;
		predict_pixels(it);
	endtask

	function automatic src_item_t noise_item();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(src_item_t)-1:0];
	endfunction

	task automatic send_data(input logic [7:0] b);
		src_item_t it;
		it = noise_item();
		it.command = CMD_DATA;
		it.data_byte = b;
		send_request(it);
	endtask

	task automatic send_palette(input logic [7:0] idx, input logic [1:0] ch, input logic [15:0] word);
		src_item_t it;
		it = noise_item();
		it.command = CMD_PALETTE;
		it.palette_index = idx;
		it.palette_channel = ch;
		it.palette_word = word;
		send_request(it);
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [23:0] rgb);
		send_palette(idx, CH_RED, {rgb[23:16], 8'($urandom())});
		send_palette(idx, CH_GREEN, {rgb[15:8], 8'($urandom())});
		send_palette(idx, CH_BLUE, {rgb[7:0], 8'($urandom())});
	endtask

	// wait until every expected pixel is out and the block has settled
	task automatic drain();
		src_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one apb transfer: setup, access, then idle
	task automatic apb_xfer(input reg_idx_t idx, input logic wr, input logic [31:0] val,
			output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input reg_idx_t idx);
		logic [31:0] rd;
		logic [31:0] exp_val;
		logic [31:0] mask;
		apb_xfer(idx, 1'b0, '0, rd);
		case (idx)
			REG_BITS_PER_PIXEL: begin
				exp_val = {27'd0, cfg_bpp};
				mask = 32'h1F;
			end
			REG_PHOTOMETRIC: begin
				exp_val = {30'd0, cfg_photo};
				mask = 32'h3;
			end
			default: begin
				exp_val = {16'd0, cfg_width};
				mask = 32'hFFFF;
			end
		endcase
		if ((rd & mask) !== exp_val)
			note_mismatch($sformatf("register %s read expected %0h got %0h",
				idx.name(), exp_val, rd));
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_xfer(idx, 1'b1, val, rd);
		case (idx)
			REG_BITS_PER_PIXEL: cfg_bpp = val[4:0];
			REG_PHOTOMETRIC:    cfg_photo = val[1:0];
			default:            cfg_width = val[15:0];
		endcase
		check_reg(idx);
	endtask

	task automatic configure(input logic [4:0] bpp, input logic [1:0] photo, input logic [15:0] width);
		drain();
		set_reg(REG_BITS_PER_PIXEL, {27'd0, bpp});
		set_reg(REG_PHOTOMETRIC, {30'd0, photo});
		set_reg(REG_IMAGE_WIDTH, {16'd0, width});
	endtask

	function automatic logic [7:0] pick_entry();
		return pal_full_q[$urandom_range(0, pal_full_q.size() - 1)];
	endfunction

	// reset values and the default gray mode
	task automatic test_reset_values();
		check_reg(REG_BITS_PER_PIXEL);
		check_reg(REG_PHOTOMETRIC);
		check_reg(REG_IMAGE_WIDTH);
		send_data(8'h00);
		send_data(8'hFF);
	endtask

	task automatic test_gray();
		configure(BPP_GRAY, PHOTO_WHITE_ZERO, 16'd3);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'h5A);
		configure(BPP_GRAY, PHOTO_BLACK_ZERO, 16'd3);
		send_data(8'h80);
	endtask

	// a full pixel, then a partial pixel dropped by a gray byte, then a full pixel again
	task automatic test_rgb();
		configure(BPP_RGB, PHOTO_RGB, 16'd2);
		send_data(8'hFF);
		send_data(8'h00);
		send_data(8'h80);
		send_data(8'h11);
		configure(BPP_GRAY, PHOTO_BLACK_ZERO, 16'd2);
		send_data(8'h22);
		configure(BPP_RGB, PHOTO_RGB, 16'd2);
		send_data(8'h33);
		send_data(8'h44);
		send_data(8'h55);
	endtask

	// palette load at both ends, ignored channel, then lookups
	task automatic test_palette();
		load_entry(8'h00, 24'hFF0080);
		load_entry(8'hFF, 24'h123456);
		repeat (4) load_entry(8'($urandom()), 24'($urandom()));
		send_palette(8'h00, 2'd3, 16'($urandom()));
		configure(BPP_GRAY, PHOTO_PALETTE, 16'd4);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(pick_entry());
	endtask

	// bilevel both polarities, row padding, width zero
	task automatic test_bilevel();
		configure(BPP_BILEVEL, PHOTO_WHITE_ZERO, 16'd11);
		send_data(8'hA5);
		send_data(8'h3C);
		configure(BPP_BILEVEL, PHOTO_BLACK_ZERO, 16'd0);
		send_data(8'h80);
	endtask

	task automatic test_unsupported();
		configure(5'd31, PHOTO_PALETTE, 16'd7);
		send_data(8'h00);
		configure(BPP_RGB, PHOTO_WHITE_ZERO, 16'd7);
		send_data(8'hFF);
		configure(5'd0, PHOTO_RGB, 16'hFFFF);
		send_data(8'h5A);
	endtask

	// width lowered below the current column
	task automatic test_column_overrun();
		configure(BPP_GRAY, PHOTO_BLACK_ZERO, 16'd6);
		send_data(8'h01);
		send_data(8'h02);
		configure(BPP_GRAY, PHOTO_BLACK_ZERO, 16'd1);
		send_data(8'h03);
	endtask

	// receiver holds off while the sender keeps offering bilevel bytes
	task automatic test_backpressure();
		configure(BPP_BILEVEL, PHOTO_WHITE_ZERO, 16'd64);
		src_gaps_on = 1'b0;
		hold_start = 1'b1;
		repeat (40) send_data(8'($urandom()));
		src_gaps_on = 1'b1;
	endtask

	// random configurations with random strip content
	task automatic test_random();
		logic [4:0]  bpp;
		logic [1:0]  photo;
		logic [15:0] width;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 7))
				0: {bpp, photo} = {BPP_RGB, PHOTO_RGB};
				1: {bpp, photo} = {BPP_GRAY, PHOTO_WHITE_ZERO};
				2: {bpp, photo} = {BPP_GRAY, PHOTO_BLACK_ZERO};
				3: {bpp, photo} = {BPP_GRAY, PHOTO_PALETTE};
				4: {bpp, photo} = {BPP_BILEVEL, PHOTO_WHITE_ZERO};
				5: {bpp, photo} = {BPP_BILEVEL, PHOTO_BLACK_ZERO};
				default: {bpp, photo} = 7'($urandom());
			endcase
			case ($urandom_range(0, 9))
				0: width = 16'd0;
				1: width = 16'hFFFF;
				2: width = 16'($urandom());
				default: width = 16'($urandom_range(1, 24));
			endcase
			configure(bpp, photo, width);
			src_gaps_on = ($urandom_range(0, 2) != 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 7) == 0)
					send_palette(8'($urandom()), 2'($urandom()), 16'($urandom()));
				if (cfg_bpp == BPP_GRAY && cfg_photo == PHOTO_PALETTE)
					send_data(pick_entry());
				else
					send_data(8'($urandom()));
			end
		end
		src_gaps_on = 1'b1;
	endtask

	initial begin
		foreach (pal_set[i])
			pal_set[i] = 3'b000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_gray();
		test_rgb();
		test_palette();
		test_bilevel();
		test_unsupported();
		test_column_overrun();
		test_backpressure();
		test_random();
		drain();
		repeat (END_CYCLES) @(posedge clk);
		$display("ran %0d data and %0d palette requests, checked %0d pixels",
			data_reqs, pal_reqs, pixels_seen);
		$display("modes: rgb, gray, palette, bilevel, unsupported; width 0 to 65535, hold-off");
		if (mismatches == 0 && pixel_q.size() == 0)
			$display("tiff_strip_pixel_unpacker_tb passed");
		else
			$display("tiff_strip_pixel_unpacker_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
